// File: sv/cbfe_pkg.sv
`timescale 1ns / 1ps

package cbfe_pkg;

  localparam int BurstDepth = 8;

  localparam logic       FUNC_HEADER  = 1'b0;
  localparam logic       FUNC_PAYLOAD = 1'b1;

  localparam logic [7:0]  FLAG_BYTE      = 8'hF9;
  localparam logic [7:0]  UIH_MASK       = 8'hEF;
  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [7:0]  CRC_POLY_REFL  = 8'hE0;
  localparam logic [14:0] MAX_INFO_RESET = 15'd127;
  localparam logic [14:0] TWO_BYTE_LENGTH_AT = 15'd128;

  // one item's worth of output bytes, oldest in entry 0
  typedef struct packed {
    logic [BurstDepth-1:0][7:0] bytes;
    logic [BurstDepth-1:0]      ends;
    logic [3:0]                 cnt;
    logic                       status;
  } burst_t;

  // reflected CRC-8 over one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/cbfe_encoder.sv
`timescale 1ns / 1ps

module cbfe_encoder import cbfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [5:0]  dlci,
  input  logic        cr,
  input  logic [7:0]  control_byte,
  input  logic [14:0] total_length,
  input  logic [7:0]  payload_byte,
  input  logic        buf_can_load,
  output logic        load,
  output burst_t      burst
);

  // input register
  logic        iq_valid;
  logic        iq_func;
  logic [5:0]  iq_dlci;
  logic        iq_cr;
  logic [7:0]  iq_ctrl;
  logic [14:0] iq_len;
  logic [7:0]  iq_byte;

  // frame state
  logic [14:0] max_info_length;
  logic        frame_open;
  logic [7:0]  address_byte;
  logic [7:0]  control_held;
  logic        uih_mode;
  logic [14:0] payload_left;
  logic [14:0] chunk_left;
  logic [7:0]  crc_acc;
  logic [7:0]  hdr_crc;

  logic        is_hdr;
  logic [7:0]  h_addr;
  logic [7:0]  h_crc;
  logic [14:0] lim;
  logic [14:0] st_len;
  logic [7:0]  st_base;
  logic [7:0]  st_addr;
  logic [7:0]  st_ctrl;
  logic [14:0] chunk;
  logic [14:0] rest;
  logic        two;
  logic [7:0]  len0;
  logic [7:0]  len1;
  logic [7:0]  c_l0;
  logic [7:0]  c_len;
  logic [7:0]  p_crc;
  logic        p_end;
  logic        do_start;

  assign load     = iq_valid && buf_can_load;
  assign in_ready = !iq_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      iq_valid <= 1'b1;
    end else if (load) begin
      iq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      iq_func <= func;
      iq_dlci <= dlci;
      iq_cr   <= cr;
      iq_ctrl <= control_byte;
      iq_len  <= total_length;
      iq_byte <= payload_byte;
    end
  end

  always_comb begin
    is_hdr  = (iq_func == FUNC_HEADER);
    h_addr  = {iq_dlci, iq_cr, 1'b1};
    h_crc   = crc8_step(crc8_step(CRC_INIT, h_addr), iq_ctrl);
    lim     = (max_info_length == '0) ? 15'd1 : max_info_length;
    st_len  = is_hdr ? iq_len : payload_left;
    st_base = is_hdr ? h_crc : hdr_crc;
    st_addr = is_hdr ? h_addr : address_byte;
    st_ctrl = is_hdr ? iq_ctrl : control_held;
    chunk   = (st_len < lim) ? st_len : lim;
    rest    = st_len - chunk;
    two     = (chunk >= TWO_BYTE_LENGTH_AT);
    len0    = {chunk[6:0], !two};
    len1    = chunk[14:7];
    c_l0    = crc8_step(st_base, len0);
    c_len   = two ? crc8_step(c_l0, len1) : c_l0;
    p_crc   = uih_mode ? crc_acc : crc8_step(crc_acc, iq_byte);
    p_end   = (chunk_left == 15'd1);
    do_start = is_hdr || (frame_open && p_end && (payload_left != '0));
  end

  // lay out the bytes this item causes
  always_comb begin
    logic [3:0] n;
    n = '0;
    burst = '0;
    if (!is_hdr) begin
      if (!frame_open) begin
        burst.status = 1'b1;
        n = 4'd1;
      end else begin
        burst.bytes[n[2:0]] = iq_byte;
        n = n + 4'd1;
        if (p_end) begin
          burst.bytes[n[2:0]] = ~p_crc;
          n = n + 4'd1;
          burst.bytes[n[2:0]] = FLAG_BYTE;
          burst.ends[n[2:0]]  = 1'b1;
          n = n + 4'd1;
        end
      end
    end
    if (do_start) begin
      burst.bytes[n[2:0]] = FLAG_BYTE;
      n = n + 4'd1;
      burst.bytes[n[2:0]] = st_addr;
      n = n + 4'd1;
      burst.bytes[n[2:0]] = st_ctrl;
      n = n + 4'd1;
      burst.bytes[n[2:0]] = len0;
      n = n + 4'd1;
      if (two) begin
        burst.bytes[n[2:0]] = len1;
        n = n + 4'd1;
      end
      if (chunk == '0) begin
        burst.bytes[n[2:0]] = ~c_len;
        n = n + 4'd1;
        burst.bytes[n[2:0]] = FLAG_BYTE;
        burst.ends[n[2:0]]  = 1'b1;
        n = n + 4'd1;
      end
    end
    burst.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_info_length <= MAX_INFO_RESET;
      frame_open      <= 1'b0;
      address_byte    <= '0;
      control_held    <= '0;
      uih_mode        <= 1'b0;
      payload_left    <= '0;
      chunk_left      <= '0;
      crc_acc         <= CRC_INIT;
      hdr_crc         <= CRC_INIT;
    end else begin
      if (cfg_we) begin
        max_info_length <= cfg_data;
      end
      if (load) begin
        if (is_hdr) begin
          address_byte <= h_addr;
          control_held <= iq_ctrl;
          uih_mode     <= ((iq_ctrl & UIH_MASK) == UIH_MASK);
          hdr_crc      <= h_crc;
        end
        if (do_start) begin
          payload_left <= rest;
          chunk_left   <= chunk;
          crc_acc      <= c_len;
          frame_open   <= (chunk != '0);
        end else if (frame_open) begin
          crc_acc    <= p_crc;
          chunk_left <= chunk_left - 15'd1;
          if (p_end) begin
            frame_open <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: sv/cbfe_burst_buf.sv
`timescale 1ns / 1ps

module cbfe_burst_buf import cbfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  burst_t     burst,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_end,
  output logic       status,
  output logic       last
);

  logic                       valid;
  logic [3:0]                 cnt;
  logic [BurstDepth-1:0][7:0] bytes;
  logic [BurstDepth-1:0]      ends;
  logic                       status_q;
  logic                       pop;

  assign pop        = valid && out_ready;
  assign can_load   = !valid || (pop && cnt == 4'd1);
  assign out_valid  = valid;
  assign frame_byte = bytes[0];
  assign frame_end  = ends[0];
  assign status     = status_q;
  assign last       = (cnt == 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      cnt   <= burst.cnt;
    end else if (pop) begin
      if (cnt == 4'd1) begin
        valid <= 1'b0;
      end
      cnt <= cnt - 4'd1;
    end
  end

  // advance one beat per accepted output
  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= burst.bytes;
      ends     <= burst.ends;
      status_q <= burst.status;
    end else if (pop) begin
      bytes <= {8'h00, bytes[BurstDepth-1:1]};
      ends  <= {1'b0, ends[BurstDepth-1:1]};
    end
  end

endmodule

// File: sv/cmux_basic_frame_encoder_unit.sv
`timescale 1ns / 1ps
// The input register holds each accepted item until the output shift buffer loads
// its bytes, which the buffer then presents one per beat. Throughput: one input
// beat per cycle while out_ready is high and each item yields one byte (payload
// bytes); an item yielding more bytes holds the input until the one-byte-per-cycle
// output shift buffer sends the last of them. Headers give 4 to 6 bytes, a payload
// byte that closes a frame gives 3, or up to 8 when it also opens the next frame.
// Reset (rst, synchronous): no frame open, max_info_length 127, buffers empty.

module cmux_basic_frame_encoder_unit import cbfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [5:0]  dlci,
  input  logic        cr,
  input  logic [7:0]  control_byte,
  input  logic [14:0] total_length,
  input  logic [7:0]  payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end,
  output logic        status,
  output logic        last
);

  logic   buf_can_load;
  logic   load;
  burst_t burst;

  cbfe_encoder u_encoder (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .dlci         (dlci),
    .cr           (cr),
    .control_byte (control_byte),
    .total_length (total_length),
    .payload_byte (payload_byte),
    .buf_can_load (buf_can_load),
    .load         (load),
    .burst        (burst)
  );

  cbfe_burst_buf u_burst_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .burst      (burst),
    .can_load   (buf_can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .status     (status),
    .last       (last)
  );

endmodule

// File: verif/cmux_basic_frame_encoder_unit_tb.sv
`timescale 1ns / 1ps

module cmux_basic_frame_encoder_unit_tb;
  import cbfe_pkg::*;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_DROPPED = 1'b1;
  localparam int   IDLE_LIMIT = 1000;

  typedef enum logic [1:0] {ROW_CFG, ROW_HDR, ROW_PAY} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [14:0] value;
    logic [5:0]  dlci;
    logic        cr;
    logic [7:0]  ctl;
    logic [7:0]  pb;
    logic        typed;
    logic [7:0]  t_byte;
    logic        t_status;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       closing;
    logic       dropped;
    logic       tail;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_HEADER;
  logic [5:0]  dlci = '0;
  logic        cr = 1'b0;
  logic [7:0]  control_byte = '0;
  logic [14:0] total_length = '0;
  logic [7:0]  payload_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic        status;
  logic        last;

  // typed expectation riding along with the current input beat
  logic        row_typed = 1'b0;
  logic [7:0]  row_tbyte = '0;
  logic        row_tstat = ST_OK;

  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int drops_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  stim_row_t   directed_steps[$];
  frame_beat_t step_beats[$];
  frame_beat_t frame_bytes_due[$];
  frame_beat_t due_beat;

  // encoder state as the predictor sees it
  logic [14:0] enc_max = MAX_INFO_RESET;
  logic        enc_open = 1'b0;
  logic [7:0]  enc_addr = '0;
  logic [7:0]  enc_ctrl = '0;
  logic        enc_uih = 1'b0;
  logic [14:0] enc_left = '0;
  logic [14:0] enc_chunk = '0;
  logic [7:0]  enc_crc = CRC_INIT;

  cmux_basic_frame_encoder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .dlci         (dlci),
    .cr           (cr),
    .control_byte (control_byte),
    .total_length (total_length),
    .payload_byte (payload_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .frame_end    (frame_end),
    .status       (status),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] fcs_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[7:1]} ^ (r[0] ? CRC_POLY_REFL : 8'h00);
    end
    return r;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic e, input logic s);
    step_beats.push_back({b, e, s, 1'b0});
  endfunction

  function automatic void push_fcs_beat(input logic [7:0] b);
    enc_crc = fcs_fold(enc_crc, b);
    push_beat(b, 1'b0, ST_OK);
  endfunction

  function automatic void close_frame();
    push_beat(~enc_crc, 1'b0, ST_OK);
    push_beat(FLAG_BYTE, 1'b1, ST_OK);
  endfunction

  function automatic void open_next_frame();
    logic [14:0] lim;
    logic [14:0] n;
    lim = (enc_max == '0) ? 15'd1 : enc_max;
    n = (enc_left < lim) ? enc_left : lim;
    enc_left = enc_left - n;
    enc_chunk = n;
    enc_crc = CRC_INIT;
    push_beat(FLAG_BYTE, 1'b0, ST_OK);
    push_fcs_beat(enc_addr);
    push_fcs_beat(enc_ctrl);
    if (n < TWO_BYTE_LENGTH_AT) begin
      push_fcs_beat({n[6:0], 1'b1});
    end else begin
      push_fcs_beat({n[6:0], 1'b0});
      push_fcs_beat(n[14:7]);
    end
    if (n == '0) begin
      close_frame();
      enc_open = 1'b0;
    end else begin
      enc_open = 1'b1;
    end
  endfunction

  // work out every beat that one accepted input item produces
  function automatic void encode_item(input logic f, input logic [5:0] d, input logic c,
                                      input logic [7:0] ctl, input logic [14:0] len,
                                      input logic [7:0] pb);
    frame_beat_t fb;
    step_beats.delete();
    if (f == FUNC_HEADER) begin
      enc_ctrl = ctl;
      enc_addr = {d, c, 1'b1};
      enc_uih = (ctl & UIH_MASK) == UIH_MASK;
      enc_left = len;
      open_next_frame();
    end else if (!enc_open) begin
      push_beat(8'h00, 1'b0, ST_DROPPED);
    end else begin
      if (enc_uih) begin
        push_beat(pb, 1'b0, ST_OK);
      end else begin
        push_fcs_beat(pb);
      end
      enc_chunk = enc_chunk - 15'd1;
      if (enc_chunk == '0) begin
        close_frame();
        if (enc_left != '0) begin
          open_next_frame();
        end else begin
          enc_open = 1'b0;
        end
      end
    end
    fb = step_beats.pop_back();
    fb.tail = 1'b1;
    step_beats.push_back(fb);
  endfunction

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // check output beats first, then queue what the accepted input beat will produce
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (frame_end) frames_closed++;
      if (status == ST_DROPPED) drops_seen++;
      if (frame_bytes_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no beat, got byte %02h end %b status %b last %b",
                 $time, frame_byte, frame_end, status, last);
      end else begin
        due_beat = frame_bytes_due.pop_front();
        if (frame_byte !== due_beat.data || frame_end !== due_beat.closing ||
            status !== due_beat.dropped || last !== due_beat.tail) begin
          mismatches++;
          $display("%0t: expected %02h %b %b %b, got %02h %b %b %b (byte end status last)",
                   $time, due_beat.data, due_beat.closing, due_beat.dropped, due_beat.tail,
                   frame_byte, frame_end, status, last);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      encode_item(func, dlci, cr, control_byte, total_length, payload_byte);
      if (row_typed) begin
        frame_bytes_due.push_back({row_tbyte, 1'b0, row_tstat, 1'b1});
      end else begin
        foreach (step_beats[i]) frame_bytes_due.push_back(step_beats[i]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("cmux_basic_frame_encoder_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic f, input logic [5:0] d, input logic c,
                           input logic [7:0] ctl, input logic [14:0] len, input logic [7:0] pb,
                           input logic typed, input logic [7:0] tbyte, input logic tstat);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid     <= 1'b1;
    func         <= f;
    dlci         <= d;
    cr           <= c;
    control_byte <= ctl;
    total_length <= len;
    payload_byte <= pb;
    row_typed    <= typed;
    row_tbyte    <= tbyte;
    row_tstat    <= tstat;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_header(input logic [7:0] ctl, input logic [14:0] len);
    send_item(FUNC_HEADER, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), ctl, len,
              8'($urandom_range(0, 255)), 1'b0, 8'h00, ST_OK);
  endtask

  task automatic send_payload(input logic [7:0] pb);
    send_item(FUNC_PAYLOAD, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)), pb,
              1'b0, 8'h00, ST_OK);
  endtask

  // hold the sender until every outstanding beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_info(input logic [14:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    enc_max = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_sequence();
    int r;
    int n;
    logic [7:0]  ctl;
    logic [14:0] len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // stray byte: dropped unless a frame happens to be open
      send_payload(8'($urandom_range(0, 255)));
    end else if (r < 18) begin
      // broken sequence: arbitrary length, cut short by whatever comes next
      send_header(8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)));
      n = $urandom_range(0, 3);
      repeat (n) send_payload(8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 12));
      if ($urandom_range(0, 1) == 1) begin
        ctl = ($urandom_range(0, 1) == 1) ? 8'hEF : 8'hFF;
      end else begin
        ctl = 8'($urandom_range(0, 255));
      end
      send_header(ctl, len);
      repeat (len) send_payload(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int gap, input int stall, input logic [14:0] maxlen,
                           input int budget, input bit long_frame);
    int start;
    bit paused;
    wait_drained();
    gap_pct = gap;
    stall_pct = stall;
    write_max_info(maxlen);
    start = items_sent;
    paused = 1'b0;
    if (long_frame) begin
      // two-byte length frame with a full info field, then a one-byte tail frame
      send_header(8'h3F, 15'd129);
      repeat (129) send_payload(8'($urandom_range(0, 255)));
    end
    while (items_sent - start < budget) begin
      if (!paused && items_sent - start >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      random_sequence();
    end
  endtask

  function automatic void add_cfg(input logic [14:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.value = v;
    directed_steps.push_back(r);
  endfunction

  function automatic void add_hdr(input logic [5:0] d, input logic c, input logic [7:0] ctl,
                                  input logic [14:0] len);
    stim_row_t r;
    r = '0;
    r.kind = ROW_HDR;
    r.dlci = d;
    r.cr = c;
    r.ctl = ctl;
    r.value = len;
    directed_steps.push_back(r);
  endfunction

  function automatic void add_pay(input logic [7:0] pb, input logic typed,
                                  input logic [7:0] tbyte, input logic tstat);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PAY;
    r.pb = pb;
    r.typed = typed;
    r.t_byte = tbyte;
    r.t_status = tstat;
    directed_steps.push_back(r);
  endfunction

  initial begin
    stim_row_t row;
    int directed_items;

    add_pay(8'hFF, 1'b1, 8'h00, ST_DROPPED);      // nothing open after reset
    add_hdr(6'd63, 1'b1, 8'hEF, 15'd0);           // empty frame
    add_pay(8'h00, 1'b1, 8'h00, ST_DROPPED);
    add_hdr(6'd0, 1'b0, 8'h00, 15'd3);
    add_pay(8'h00, 1'b0, 8'h00, ST_OK);
    add_pay(8'hFF, 1'b0, 8'h00, ST_OK);
    add_pay(8'hA5, 1'b0, 8'h00, ST_OK);
    add_hdr(6'd21, 1'b1, 8'hFF, 15'd2);           // UIH with poll bit
    add_pay(8'h00, 1'b1, 8'h00, ST_OK);
    add_pay(8'hFF, 1'b0, 8'h00, ST_OK);
    add_hdr(6'd7, 1'b0, 8'h3F, 15'd5);
    add_pay(8'h12, 1'b0, 8'h00, ST_OK);
    add_hdr(6'd9, 1'b1, 8'hEF, 15'd1);            // abandon the open frame
    add_pay(8'h34, 1'b0, 8'h00, ST_OK);
    add_cfg(15'd2);
    add_hdr(6'd33, 1'b0, 8'h2F, 15'd5);           // split 2 + 2 + 1
    add_pay(8'h01, 1'b0, 8'h00, ST_OK);
    add_pay(8'h80, 1'b0, 8'h00, ST_OK);
    add_pay(8'h7F, 1'b0, 8'h00, ST_OK);
    add_pay(8'hFE, 1'b0, 8'h00, ST_OK);
    add_pay(8'h55, 1'b0, 8'h00, ST_OK);
    add_cfg(15'd0);                               // behaves as one
    add_hdr(6'd1, 1'b0, 8'hEF, 15'd2);
    add_pay(8'hC3, 1'b0, 8'h00, ST_OK);
    add_pay(8'h3C, 1'b0, 8'h00, ST_OK);
    add_cfg(15'd32767);
    add_hdr(6'd42, 1'b1, 8'h53, 15'd32767);       // widest two-byte length
    add_hdr(6'd12, 1'b0, 8'hEF, 15'd128);
    add_hdr(6'd50, 1'b1, 8'hEF, 15'd127);         // widest one-byte length
    add_pay(8'h5A, 1'b1, 8'h5A, ST_OK);
    add_cfg(MAX_INFO_RESET);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 7;
    stall_pct = 62;
    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      case (row.kind)
        ROW_CFG: begin
          wait_drained();
          write_max_info(row.value);
        end
        ROW_HDR: begin
          send_item(FUNC_HEADER, row.dlci, row.cr, row.ctl, row.value,
                    8'($urandom_range(0, 255)), 1'b0, 8'h00, ST_OK);
        end
        default: begin
          send_item(FUNC_PAYLOAD, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)), row.pb,
                    row.typed, row.t_byte, row.t_status);
        end
      endcase
    end
    directed_items = items_sent;

    run_phase(7, 62, 15'd1, 20, 1'b0);
    run_phase(62, 7, 15'd6, 20, 1'b0);
    run_phase(0, 0, 15'd128, 140, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d input items (%0d directed), info limits 0, 1, 2, 6, 127, 128, 32767",
             items_sent, directed_items);
    $display("checked %0d frame bytes, %0d frames closed, %0d drops, %0d mismatches",
             bytes_checked, frames_closed, drops_seen, mismatches);
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("cmux_basic_frame_encoder_unit regression: pass");
    end else begin
      $display("cmux_basic_frame_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
